// ===== rtl/tah_pkg.sv =====
// Shared types, constants and codes of the triggered ADC histogrammer.
`default_nettype none

package tah_pkg;

   // Field widths of the request and response items
   localparam int unsigned CMD_W     = 2;
   localparam int unsigned TRIG_W    = 16;
   localparam int unsigned CSUM_W    = 32;
   localparam int unsigned HALF_W    = 16;
   localparam int unsigned SEC_W     = 32;
   localparam int unsigned CHAN_W    = 2;
   localparam int unsigned SAMPLE_W  = 12;
   localparam int unsigned KIND_W    = 2;
   localparam int unsigned BIN_W     = 10;
   localparam int unsigned RD_CNT_W  = 32;

   // Widest count the COUNT_BITS range allows
   localparam int unsigned CNT_MAX_W = 48;

   // Histogram kinds, one RAM bank each
   localparam int unsigned KINDS    = 4;
   localparam int unsigned KIND_ALL = 0;
   localparam int unsigned KIND_THM = 1;
   localparam int unsigned KIND_FRC = 2;
   localparam int unsigned KIND_HRT = 3;

   // Default parameter values
   localparam int unsigned CHANNELS_DEF   = 4;
   localparam int unsigned BINS_DEF       = 1024;
   localparam int unsigned COUNT_BITS_DEF = 32;

   // Queue between front and back
   localparam int unsigned QUEUE_DEPTH = 2;

   // Register indexes of the configuration port
   localparam int unsigned CSR_IDX_W = 1;
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_CHECKSUM_CHECK_ENABLE = 1'b0,
      CSR_HEARTBEAT_ENABLE      = 1'b1
   } csr_index_type;

   // Trigger codes
   localparam logic [TRIG_W-1:0] TRIG_THERMAL = 16'd0;
   localparam logic [TRIG_W-1:0] TRIG_FORCED  = 16'd1;

   typedef enum logic [CMD_W-1:0] {
      CMD_HEADER = 2'd0,
      CMD_SAMPLE = 2'd1,
      CMD_READ   = 2'd2,
      CMD_UNUSED = 2'd3
   } cmd_type;

   // Work handed to the back part
   typedef enum logic [1:0] {
      OP_NONE = 2'd0,
      OP_BUMP = 2'd1,
      OP_READ = 2'd2
   } op_type;

   typedef struct packed {
      logic ok;
      logic thermal;
      logic forced;
      logic heartbeat;
   } flags_type;

   typedef struct packed {
      op_type              op;
      logic [KINDS-1:0]    banks;
      logic [KIND_W-1:0]   kind;
      logic [CHAN_W-1:0]   channel;
      logic [BIN_W-1:0]    bin;
      flags_type           flags;
   } entry_type;

   typedef enum logic [1:0] {
      BK_CLEAR = 2'd0,
      BK_FETCH = 2'd1,
      BK_EXEC  = 2'd2
   } back_state_type;

endpackage

`default_nettype wire

// ===== rtl/tah_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module tah_ram #(
   parameter int unsigned WIDTH = 32,
   parameter int unsigned DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output      logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

`default_nettype wire

// ===== rtl/tah_front.sv =====
// Front part: classifies items, tracks event flags and heartbeat timing.
`default_nettype none

module tah_front #(
   parameter int unsigned CHANNELS = tah_pkg::CHANNELS_DEF,
   parameter int unsigned BINS     = tah_pkg::BINS_DEF
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          accept,
   input  wire logic                          chk_en,
   input  wire logic                          hb_en,
   input  wire logic [tah_pkg::CMD_W-1:0]     command,
   input  wire logic [tah_pkg::TRIG_W-1:0]    trigger_code,
   input  wire logic [tah_pkg::CSUM_W-1:0]    board_checksum,
   input  wire logic [tah_pkg::HALF_W-1:0]    checksum_low_half,
   input  wire logic [tah_pkg::HALF_W-1:0]    checksum_high_half,
   input  wire logic [tah_pkg::SEC_W-1:0]     event_seconds,
   input  wire logic [tah_pkg::CHAN_W-1:0]    channel,
   input  wire logic [tah_pkg::SAMPLE_W-1:0]  sample_value,
   input  wire logic [tah_pkg::KIND_W-1:0]    histogram_kind,
   input  wire logic [tah_pkg::BIN_W-1:0]     bin_index,
   output      tah_pkg::entry_type            entry
);

   logic                      first_seen_ff, first_seen_in;
   logic [tah_pkg::SEC_W-1:0] last_thm_ff, last_thm_in;
   logic [tah_pkg::SEC_W-1:0] last_hb_ff, last_hb_in;
   tah_pkg::flags_type        flags_ff, flags_in;

   logic [tah_pkg::SEC_W-1:0] thm_ref;
   logic [tah_pkg::SEC_W-1:0] diff;
   logic                      hdr_hrt;
   tah_pkg::flags_type        hdr_flags;
   logic [tah_pkg::BIN_W-1:0] sample_bin;
   logic                      chan_ok;
   logic                      sample_bin_ok;
   logic                      read_bin_ok;

   // Header classification
   always_comb begin
      thm_ref = first_seen_ff ? last_thm_ff : event_seconds;
      diff = event_seconds - ((last_hb_ff == '0) ? thm_ref : last_hb_ff);
      hdr_flags.ok = chk_en ?
         (board_checksum == {checksum_high_half, checksum_low_half}) : 1'b1;
      hdr_flags.thermal = (trigger_code == tah_pkg::TRIG_THERMAL);
      hdr_flags.forced  = (trigger_code == tah_pkg::TRIG_FORCED);
      hdr_hrt = hdr_flags.thermal && (diff == tah_pkg::SEC_W'(1));
      hdr_flags.heartbeat = hdr_hrt;
   end

   always_comb begin
      first_seen_in = first_seen_ff;
      last_thm_in   = last_thm_ff;
      last_hb_in    = last_hb_ff;
      flags_in      = flags_ff;
      if (accept && (command == tah_pkg::CMD_HEADER)) begin
         first_seen_in = 1'b1;
         flags_in      = hdr_flags;
         last_thm_in   = (hdr_flags.thermal && (last_hb_ff == '0)) ? event_seconds : thm_ref;
         if (hdr_hrt) begin
            last_hb_in = event_seconds;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         first_seen_ff <= 1'b0;
         last_thm_ff   <= '0;
         last_hb_ff    <= '0;
         flags_ff      <= '0;
      end else begin
         first_seen_ff <= first_seen_in;
         last_thm_ff   <= last_thm_in;
         last_hb_ff    <= last_hb_in;
         flags_ff      <= flags_in;
      end
   end

   // Work item for the back part
   always_comb begin
      sample_bin    = sample_value[tah_pkg::SAMPLE_W-1:2];
      chan_ok       = int'(channel) < CHANNELS;
      sample_bin_ok = int'(sample_bin) < BINS;
      read_bin_ok   = int'(bin_index) < BINS;

      entry.op      = tah_pkg::OP_NONE;
      entry.banks   = '0;
      entry.kind    = histogram_kind;
      entry.channel = channel;
      entry.bin     = bin_index;
      entry.flags   = flags_in;

      case (command)
         tah_pkg::CMD_SAMPLE: begin
            entry.bin = sample_bin;
            if (flags_ff.ok && chan_ok && sample_bin_ok) begin
               entry.op = tah_pkg::OP_BUMP;
               entry.banks[tah_pkg::KIND_ALL] = 1'b1;
               entry.banks[tah_pkg::KIND_THM] = flags_ff.thermal;
               entry.banks[tah_pkg::KIND_HRT] =
                  flags_ff.thermal && flags_ff.heartbeat && hb_en;
               entry.banks[tah_pkg::KIND_FRC] = !flags_ff.thermal && flags_ff.forced;
            end
         end
         tah_pkg::CMD_READ: begin
            if (chan_ok && read_bin_ok) begin
               entry.op = tah_pkg::OP_READ;
            end
         end
         default: begin
            entry.op = tah_pkg::OP_NONE;
         end
      endcase
   end

endmodule

`default_nettype wire

// ===== rtl/tah_queue.sv =====
// Short register queue between the front and back parts.
`default_nettype none

module tah_queue (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               push,
   input  wire tah_pkg::entry_type push_data,
   input  wire logic               pop,
   output      tah_pkg::entry_type head,
   output      logic               full,
   output      logic               empty
);

   localparam int unsigned PTR_W = $clog2(tah_pkg::QUEUE_DEPTH);
   localparam int unsigned CNT_W = $clog2(tah_pkg::QUEUE_DEPTH + 1);

   tah_pkg::entry_type slot_ff [tah_pkg::QUEUE_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;

   function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
      logic [PTR_W-1:0] r;
      if (int'(p) == tah_pkg::QUEUE_DEPTH - 1) begin
         r = '0;
      end else begin
         r = p + PTR_W'(1);
      end
      return r;
   endfunction

   always_comb begin
      full      = (int'(count_ff) == tah_pkg::QUEUE_DEPTH);
      empty     = (count_ff == '0);
      head      = slot_ff[rd_ptr_ff];
      wr_ptr_in = push ? ptr_next(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop ? ptr_next(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/tah_back.sv =====
// Back part: histogram banks, clearing pass, read-modify-write and results.
`default_nettype none

module tah_back #(
   parameter int unsigned CHANNELS   = tah_pkg::CHANNELS_DEF,
   parameter int unsigned BINS       = tah_pkg::BINS_DEF,
   parameter int unsigned COUNT_BITS = tah_pkg::COUNT_BITS_DEF
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          q_empty,
   input  wire tah_pkg::entry_type            q_head,
   output      logic                          q_pop,
   output      logic                          clearing,
   output      logic                          rsp_valid,
   input  wire logic                          rsp_ready,
   output      logic                          rsp_event_ok,
   output      logic                          rsp_event_thermal,
   output      logic                          rsp_event_forced,
   output      logic                          rsp_event_heartbeat,
   output      logic [tah_pkg::RD_CNT_W-1:0]  rsp_bin_count
);

   localparam int unsigned DEPTH = CHANNELS * BINS;
   localparam int unsigned AW    = $clog2(DEPTH);

   tah_pkg::back_state_type state_ff, state_in;
   logic [AW-1:0]           clr_addr_ff, clr_addr_in;
   tah_pkg::entry_type      cur_ff, cur_in;
   logic [AW-1:0]           cur_addr_ff, cur_addr_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   tah_pkg::flags_type      rsp_flags_ff, rsp_flags_in;
   logic [tah_pkg::RD_CNT_W-1:0] rsp_count_ff, rsp_count_in;

   logic [AW-1:0]           head_addr;
   logic [AW-1:0]           rd_addr;
   logic [AW-1:0]           wr_addr;
   logic [tah_pkg::KINDS-1:0] wr_en;
   logic [COUNT_BITS-1:0]   rd_data [tah_pkg::KINDS];
   logic [COUNT_BITS-1:0]   wr_data [tah_pkg::KINDS];
   logic                    out_free;
   logic                    load_rsp;
   logic [COUNT_BITS-1:0]   sel_count;
   logic [tah_pkg::CNT_MAX_W-1:0] wide_count;

   assign head_addr = AW'(int'(q_head.channel) * BINS + int'(q_head.bin));
   assign out_free  = !rsp_valid_ff || rsp_ready;

   for (genvar k = 0; k < tah_pkg::KINDS; k++) begin : g_bank
      tah_ram #(
         .WIDTH (COUNT_BITS),
         .DEPTH (DEPTH)
      ) u_ram (
         .clock   (clock),
         .wr_en   (wr_en[k]),
         .wr_addr (wr_addr),
         .wr_data (wr_data[k]),
         .rd_addr (rd_addr),
         .rd_data (rd_data[k])
      );
      // saturating increment, or zero during the clearing pass
      assign wr_data[k] = (state_ff == tah_pkg::BK_CLEAR) ? '0 :
         ((rd_data[k] == {COUNT_BITS{1'b1}}) ? rd_data[k] :
          rd_data[k] + COUNT_BITS'(1));
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         tah_pkg::BK_CLEAR: begin
            if (clr_addr_ff == AW'(DEPTH - 1)) begin
               state_in = tah_pkg::BK_FETCH;
            end
         end
         tah_pkg::BK_FETCH: begin
            if (!q_empty) begin
               state_in = tah_pkg::BK_EXEC;
            end
         end
         tah_pkg::BK_EXEC: begin
            if (out_free) begin
               state_in = tah_pkg::BK_FETCH;
            end
         end
         default: begin
            state_in = tah_pkg::BK_CLEAR;
         end
      endcase
   end

   // Outputs of the sequencer
   always_comb begin
      clearing = 1'b0;
      q_pop    = 1'b0;
      load_rsp = 1'b0;
      rd_addr  = cur_addr_ff;
      wr_addr  = cur_addr_ff;
      wr_en    = '0;
      case (state_ff)
         tah_pkg::BK_CLEAR: begin
            clearing = 1'b1;
            wr_addr  = clr_addr_ff;
            wr_en    = '1;
         end
         tah_pkg::BK_FETCH: begin
            q_pop   = !q_empty;
            rd_addr = head_addr;
         end
         tah_pkg::BK_EXEC: begin
            load_rsp = out_free;
            if (out_free && (cur_ff.op == tah_pkg::OP_BUMP)) begin
               wr_en = cur_ff.banks;
            end
         end
         default: begin
            clearing = 1'b0;
         end
      endcase
   end

   // Read result: pick the bank, clamp wide counts to 32 bits; non-read items answer zero
   always_comb begin
      sel_count  = rd_data[cur_ff.kind];
      wide_count = tah_pkg::CNT_MAX_W'(sel_count);
      rsp_count_in = rsp_count_ff;
      rsp_flags_in = rsp_flags_ff;
      if (load_rsp) begin
         rsp_flags_in = cur_ff.flags;
         if (cur_ff.op != tah_pkg::OP_READ) begin
            rsp_count_in = '0;
         end else if (|wide_count[tah_pkg::CNT_MAX_W-1:tah_pkg::RD_CNT_W]) begin
            rsp_count_in = '1;
         end else begin
            rsp_count_in = wide_count[tah_pkg::RD_CNT_W-1:0];
         end
      end
      rsp_valid_in = load_rsp ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);
      clr_addr_in  = clearing ? clr_addr_ff + AW'(1) : clr_addr_ff;
      cur_in       = q_pop ? q_head : cur_ff;
      cur_addr_in  = q_pop ? head_addr : cur_addr_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= tah_pkg::BK_CLEAR;
         clr_addr_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_addr_ff  <= clr_addr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff       <= cur_in;
      cur_addr_ff  <= cur_addr_in;
      rsp_flags_ff <= rsp_flags_in;
      rsp_count_ff <= rsp_count_in;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_event_ok        = rsp_flags_ff.ok;
   assign rsp_event_thermal   = rsp_flags_ff.thermal;
   assign rsp_event_forced    = rsp_flags_ff.forced;
   assign rsp_event_heartbeat = rsp_flags_ff.heartbeat;
   assign rsp_bin_count       = rsp_count_ff;

endmodule

`default_nettype wire

// ===== rtl/triggered_adc_histogrammer.sv =====
// Top level of the triggered ADC histogrammer: front, queue, back and control registers.
//
// Each request returns exactly one response carrying the current event
// flags; reads also return a bin count clamped to 32 bits. Internally a
// front part classifies requests and keeps the event and heartbeat state,
// a two-entry queue decouples it from the back part, and the back part
// owns four histogram banks (all, thermal, forced, heartbeat), each a RAM
// of CHANNELS*BINS counts. For each item the back part reads the banks at
// the item's address, then writes the saturated increments and loads the
// response register, waiting while an unaccepted response is held; it
// takes the next item only after that, so the rate is bounded by that
// read-modify-write on the bank ports. After reset the banks are zeroed
// by a clearing pass over all CHANNELS*BINS addresses, during which
// req_ready is low; configuration writes are taken at any time.
`default_nettype none

module triggered_adc_histogrammer #(
   parameter int unsigned CHANNELS   = tah_pkg::CHANNELS_DEF,
   parameter int unsigned BINS       = tah_pkg::BINS_DEF,
   parameter int unsigned COUNT_BITS = tah_pkg::COUNT_BITS_DEF
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   // request channel
   input  wire logic                           req_valid,
   output      logic                           req_ready,
   input  wire logic [tah_pkg::CMD_W-1:0]      req_command,
   input  wire logic [tah_pkg::TRIG_W-1:0]     req_trigger_code,
   input  wire logic [tah_pkg::CSUM_W-1:0]     req_board_checksum,
   input  wire logic [tah_pkg::HALF_W-1:0]     req_checksum_low_half,
   input  wire logic [tah_pkg::HALF_W-1:0]     req_checksum_high_half,
   input  wire logic [tah_pkg::SEC_W-1:0]      req_event_seconds,
   input  wire logic [tah_pkg::CHAN_W-1:0]     req_channel,
   input  wire logic [tah_pkg::SAMPLE_W-1:0]   req_sample_value,
   input  wire logic [tah_pkg::KIND_W-1:0]     req_histogram_kind,
   input  wire logic [tah_pkg::BIN_W-1:0]      req_bin_index,
   // response channel
   output      logic                           rsp_valid,
   input  wire logic                           rsp_ready,
   output      logic                           rsp_event_ok,
   output      logic                           rsp_event_thermal,
   output      logic                           rsp_event_forced,
   output      logic                           rsp_event_heartbeat,
   output      logic [tah_pkg::RD_CNT_W-1:0]   rsp_bin_count,
   // control registers
   input  wire logic                           csr_we,
   input  wire logic [tah_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic                           csr_wdata
);

   logic               chk_en_ff, chk_en_in;
   logic               hb_en_ff, hb_en_in;
   logic               req_xfer;
   logic               q_full;
   logic               q_empty;
   logic               q_pop;
   logic               clearing;
   tah_pkg::entry_type front_entry;
   tah_pkg::entry_type q_head;

   // Control registers, write only
   always_comb begin
      chk_en_in = chk_en_ff;
      hb_en_in  = hb_en_ff;
      if (csr_we) begin
         case (csr_index)
            tah_pkg::CSR_CHECKSUM_CHECK_ENABLE: chk_en_in = csr_wdata;
            tah_pkg::CSR_HEARTBEAT_ENABLE:      hb_en_in  = csr_wdata;
            default: begin
               chk_en_in = chk_en_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         chk_en_ff <= 1'b1;
         hb_en_ff  <= 1'b0;
      end else begin
         chk_en_ff <= chk_en_in;
         hb_en_ff  <= hb_en_in;
      end
   end

   // A request transfers whenever the queue has room and the banks are cleared
   assign req_ready = !clearing && !q_full;
   assign req_xfer  = req_valid && req_ready;

   tah_front #(
      .CHANNELS (CHANNELS),
      .BINS     (BINS)
   ) u_front (
      .clock              (clock),
      .reset              (reset),
      .accept             (req_xfer),
      .chk_en             (chk_en_ff),
      .hb_en              (hb_en_ff),
      .command            (req_command),
      .trigger_code       (req_trigger_code),
      .board_checksum     (req_board_checksum),
      .checksum_low_half  (req_checksum_low_half),
      .checksum_high_half (req_checksum_high_half),
      .event_seconds      (req_event_seconds),
      .channel            (req_channel),
      .sample_value       (req_sample_value),
      .histogram_kind     (req_histogram_kind),
      .bin_index          (req_bin_index),
      .entry              (front_entry)
   );

   tah_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (req_xfer),
      .push_data (front_entry),
      .pop       (q_pop),
      .head      (q_head),
      .full      (q_full),
      .empty     (q_empty)
   );

   // Back part: bank RMW plus the response register (acts as the skid stage)
   tah_back #(
      .CHANNELS   (CHANNELS),
      .BINS       (BINS),
      .COUNT_BITS (COUNT_BITS)
   ) u_back (
      .clock               (clock),
      .reset               (reset),
      .q_empty             (q_empty),
      .q_head              (q_head),
      .q_pop               (q_pop),
      .clearing            (clearing),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_event_ok        (rsp_event_ok),
      .rsp_event_thermal   (rsp_event_thermal),
      .rsp_event_forced    (rsp_event_forced),
      .rsp_event_heartbeat (rsp_event_heartbeat),
      .rsp_bin_count       (rsp_bin_count)
   );

endmodule

`default_nettype wire

// ===== rtl/tah_checker.sv =====
// Port-level checker of the histogrammer and its bind.
`default_nettype none

module tah_checker (
   input wire logic                          clock,
   input wire logic                          reset,
   input wire logic                          req_valid,
   input wire logic                          req_ready,
   input wire logic                          rsp_valid,
   input wire logic                          rsp_ready,
   input wire logic                          rsp_event_ok,
   input wire logic                          rsp_event_thermal,
   input wire logic                          rsp_event_forced,
   input wire logic                          rsp_event_heartbeat,
   input wire logic [tah_pkg::RD_CNT_W-1:0]  rsp_bin_count
);

   logic [3:0] pending_ff, pending_in;

   // requests transferred but not yet answered
   always_comb begin
      pending_in = pending_ff + 4'(req_valid && req_ready) - 4'(rsp_valid && rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= '0;
      end else begin
         pending_ff <= pending_in;
      end
   end

   a_no_ready_after_reset: assert property (@(posedge clock)
      reset |=> !req_ready)
      else $error("request ready right after reset");

   a_rsp_has_request: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> pending_ff != 4'd0)
      else $error("response without a pending request");

   a_heartbeat_is_thermal: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_event_heartbeat |-> rsp_event_thermal && !rsp_event_forced)
      else $error("heartbeat flagged on a non-thermal event");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_bin_count)
         && $stable(rsp_event_ok))
      else $error("stalled response changed");

endmodule

bind triggered_adc_histogrammer tah_checker u_checker (.*);

`default_nettype wire

// ===== bench/tah_response_checker.sv =====
// Response checker: predicts each response of the histogrammer and compares it on transfer.
`timescale 1ns / 100ps

module tah_response_checker (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_valid,
   input  wire logic                           req_ready,
   input  wire logic [tah_pkg::CMD_W-1:0]      req_command,
   input  wire logic [tah_pkg::TRIG_W-1:0]     req_trigger_code,
   input  wire logic [tah_pkg::CSUM_W-1:0]     req_board_checksum,
   input  wire logic [tah_pkg::HALF_W-1:0]     req_checksum_low_half,
   input  wire logic [tah_pkg::HALF_W-1:0]     req_checksum_high_half,
   input  wire logic [tah_pkg::SEC_W-1:0]      req_event_seconds,
   input  wire logic [tah_pkg::CHAN_W-1:0]     req_channel,
   input  wire logic [tah_pkg::SAMPLE_W-1:0]   req_sample_value,
   input  wire logic [tah_pkg::KIND_W-1:0]     req_histogram_kind,
   input  wire logic [tah_pkg::BIN_W-1:0]      req_bin_index,
   input  wire logic                           rsp_valid,
   input  wire logic                           rsp_ready,
   input  wire logic                           rsp_event_ok,
   input  wire logic                           rsp_event_thermal,
   input  wire logic                           rsp_event_forced,
   input  wire logic                           rsp_event_heartbeat,
   input  wire logic [tah_pkg::RD_CNT_W-1:0]   rsp_bin_count,
   input  wire logic                           csr_we,
   input  wire logic [tah_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic                           csr_wdata,
   output int unsigned                         mismatch_count,
   output int unsigned                         responses_owed
);
   import tah_pkg::*;

   localparam int unsigned CHANNELS   = CHANNELS_DEF;
   localparam int unsigned BINS       = BINS_DEF;
   localparam int unsigned COUNT_BITS = COUNT_BITS_DEF;
   localparam logic [COUNT_BITS-1:0] COUNT_TOP = '1;
   localparam int unsigned PRINT_CAP  = 50;

   typedef struct packed {
      flags_type             flags;
      logic [RD_CNT_W-1:0]   count;
   } response_type;

   // shadow of the block's state
   logic [COUNT_BITS-1:0] shadow_counts [KINDS][CHANNELS][BINS];
   logic [SEC_W-1:0]      thermal_sec;
   logic [SEC_W-1:0]      beat_sec;
   logic                  any_header;
   flags_type             event_flags;
   logic                  check_on;
   logic                  beat_on;
   response_type          owed_responses [$];
   response_type          fresh;

   initial begin
      mismatch_count = 0;
      responses_owed = 0;
   end

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      if (mismatch_count < PRINT_CAP)
         $display("%0t ns: mismatch on %s: got %0h, expected %0h", $time, what, got, want);
      mismatch_count++;
   endtask

   task automatic bump(input int unsigned kind, input int unsigned ch, input int unsigned bin);
      if (shadow_counts[kind][ch][bin] != COUNT_TOP)
         shadow_counts[kind][ch][bin]++;
   endtask

   task automatic predict_response(output response_type rsp);
      logic                  beat;
      logic [BIN_W-1:0]      bin;
      logic [63:0]           stored;
      rsp.count = '0;
      case (cmd_type'(req_command))
         CMD_HEADER: begin
            // the very first header of any kind seeds the thermal reference
            if (!any_header) begin
               thermal_sec = req_event_seconds;
               any_header  = 1'b1;
            end
            event_flags.ok = !check_on ||
               (req_board_checksum == {req_checksum_high_half, req_checksum_low_half});
            event_flags.thermal = (req_trigger_code == TRIG_THERMAL);
            event_flags.forced  = (req_trigger_code == TRIG_FORCED);
            beat = 1'b0;
            if (event_flags.thermal) begin
               // zero beat_sec means no heartbeat yet: test against last thermal time
               if (beat_sec == '0) begin
                  beat = (SEC_W'(req_event_seconds - thermal_sec) == SEC_W'(1));
                  thermal_sec = req_event_seconds;
               end else begin
                  beat = (SEC_W'(req_event_seconds - beat_sec) == SEC_W'(1));
               end
               if (beat)
                  beat_sec = req_event_seconds;
            end
            event_flags.heartbeat = beat;
         end
         CMD_SAMPLE: begin
            bin = req_sample_value[SAMPLE_W-1:2];
            if (event_flags.ok && req_channel < CHANNELS && bin < BINS) begin
               bump(KIND_ALL, req_channel, bin);
               if (event_flags.thermal) begin
                  bump(KIND_THM, req_channel, bin);
                  if (event_flags.heartbeat && beat_on)
                     bump(KIND_HRT, req_channel, bin);
               end else if (event_flags.forced) begin
                  bump(KIND_FRC, req_channel, bin);
               end
            end
         end
         CMD_READ: begin
            if (req_channel < CHANNELS && req_bin_index < BINS) begin
               stored = 64'(shadow_counts[req_histogram_kind][req_channel][req_bin_index]);
               rsp.count = (stored > 64'hFFFF_FFFF) ? '1 : stored[RD_CNT_W-1:0];
            end
         end
         default: ;
      endcase
      rsp.flags = event_flags;
   endtask

   task automatic check_response();
      response_type want;
      if (owed_responses.size() == 0) begin
         report_mismatch("response with none owed", rsp_bin_count, 0);
         return;
      end
      want = owed_responses.pop_front();
      if (rsp_event_ok !== want.flags.ok)
         report_mismatch("event_ok", rsp_event_ok, want.flags.ok);
      if (rsp_event_thermal !== want.flags.thermal)
         report_mismatch("event_thermal", rsp_event_thermal, want.flags.thermal);
      if (rsp_event_forced !== want.flags.forced)
         report_mismatch("event_forced", rsp_event_forced, want.flags.forced);
      if (rsp_event_heartbeat !== want.flags.heartbeat)
         report_mismatch("event_heartbeat", rsp_event_heartbeat, want.flags.heartbeat);
      if (rsp_bin_count !== want.count)
         report_mismatch("bin_count", rsp_bin_count, want.count);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         foreach (shadow_counts[k, c, b])
            shadow_counts[k][c][b] = '0;
         thermal_sec = '0;
         beat_sec    = '0;
         any_header  = 1'b0;
         event_flags = '0;
         check_on    = 1'b1;
         beat_on     = 1'b0;
         owed_responses.delete();
      end else begin
         if (csr_we) begin
            case (csr_index_type'(csr_index))
               CSR_CHECKSUM_CHECK_ENABLE: check_on = csr_wdata;
               CSR_HEARTBEAT_ENABLE:      beat_on  = csr_wdata;
               default: ;
            endcase
         end
         // a response never belongs to a request taken at the same edge
         if (rsp_valid && rsp_ready)
            check_response();
         if (req_valid && req_ready) begin
            predict_response(fresh);
            owed_responses.push_back(fresh);
         end
      end
      responses_owed <= owed_responses.size();
   end

endmodule

// ===== bench/triggered_adc_histogrammer_test.sv =====
// Top of the histogrammer testbench: clock, reset, stimulus, receiver stalls and verdict.
`timescale 1ns / 100ps

module triggered_adc_histogrammer_test;
   import tah_pkg::*;

   // Watchdog limit on cycles without any transfer. The longest quiet stretch of a
   // correct run is the clearing pass after reset.
   localparam int unsigned QUIET_LIMIT = 12000;
   // Length of the deliberate receiver hold that backs up the block.
   localparam int unsigned HOLD_CYCLES = 300;
   // Cycles allowed to pass after the last response before the verdict.
   localparam int unsigned TAIL_CYCLES = 20;

   typedef struct packed {
      cmd_type               command;
      logic [TRIG_W-1:0]     trigger_code;
      logic [CSUM_W-1:0]     board_checksum;
      logic [HALF_W-1:0]     checksum_low_half;
      logic [HALF_W-1:0]     checksum_high_half;
      logic [SEC_W-1:0]      event_seconds;
      logic [CHAN_W-1:0]     channel;
      logic [SAMPLE_W-1:0]   sample_value;
      logic [KIND_W-1:0]     histogram_kind;
      logic [BIN_W-1:0]      bin_index;
   } request_type;

   // receiver stall patterns
   typedef enum logic [1:0] {
      RX_STEADY = 2'd0,    // always ready
      RX_MOSTLY = 2'd1,    // ready with probability three in four
      RX_SPARSE = 2'd2,    // ready with probability one in four
      RX_TOGGLE = 2'd3     // alternates ready and not ready
   } rx_mode_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;

   logic                  req_valid = 1'b0;
   logic                  req_ready;
   logic [CMD_W-1:0]      req_command = '0;
   logic [TRIG_W-1:0]     req_trigger_code = '0;
   logic [CSUM_W-1:0]     req_board_checksum = '0;
   logic [HALF_W-1:0]     req_checksum_low_half = '0;
   logic [HALF_W-1:0]     req_checksum_high_half = '0;
   logic [SEC_W-1:0]      req_event_seconds = '0;
   logic [CHAN_W-1:0]     req_channel = '0;
   logic [SAMPLE_W-1:0]   req_sample_value = '0;
   logic [KIND_W-1:0]     req_histogram_kind = '0;
   logic [BIN_W-1:0]      req_bin_index = '0;

   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   logic                  rsp_event_ok;
   logic                  rsp_event_thermal;
   logic                  rsp_event_forced;
   logic                  rsp_event_heartbeat;
   logic [RD_CNT_W-1:0]   rsp_bin_count;

   logic                  csr_we = 1'b0;
   csr_index_type         csr_index = CSR_CHECKSUM_CHECK_ENABLE;
   logic                  csr_wdata = 1'b0;

   int unsigned           mismatch_count;
   int unsigned           responses_owed;

   // stimulus bookkeeping
   int unsigned           items_sent = 0;      // transfers other than the unused command
   int unsigned           burst_left = 0;      // items still to go back to back
   bit                    hold_request = 1'b0; // asks the receiver for a long hold
   logic [SEC_W-1:0]      last_beat_sec;       // time of the last heartbeat we sent

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   triggered_adc_histogrammer u_top (
      .clock                  (clock),
      .reset                  (reset),
      .req_valid              (req_valid),
      .req_ready              (req_ready),
      .req_command            (req_command),
      .req_trigger_code       (req_trigger_code),
      .req_board_checksum     (req_board_checksum),
      .req_checksum_low_half  (req_checksum_low_half),
      .req_checksum_high_half (req_checksum_high_half),
      .req_event_seconds      (req_event_seconds),
      .req_channel            (req_channel),
      .req_sample_value       (req_sample_value),
      .req_histogram_kind     (req_histogram_kind),
      .req_bin_index          (req_bin_index),
      .rsp_valid              (rsp_valid),
      .rsp_ready              (rsp_ready),
      .rsp_event_ok           (rsp_event_ok),
      .rsp_event_thermal      (rsp_event_thermal),
      .rsp_event_forced       (rsp_event_forced),
      .rsp_event_heartbeat    (rsp_event_heartbeat),
      .rsp_bin_count          (rsp_bin_count),
      .csr_we                 (csr_we),
      .csr_index              (csr_index),
      .csr_wdata              (csr_wdata)
   );

   tah_response_checker u_checker (
      .clock                  (clock),
      .reset                  (reset),
      .req_valid              (req_valid),
      .req_ready              (req_ready),
      .req_command            (req_command),
      .req_trigger_code       (req_trigger_code),
      .req_board_checksum     (req_board_checksum),
      .req_checksum_low_half  (req_checksum_low_half),
      .req_checksum_high_half (req_checksum_high_half),
      .req_event_seconds      (req_event_seconds),
      .req_channel            (req_channel),
      .req_sample_value       (req_sample_value),
      .req_histogram_kind     (req_histogram_kind),
      .req_bin_index          (req_bin_index),
      .rsp_valid              (rsp_valid),
      .rsp_ready              (rsp_ready),
      .rsp_event_ok           (rsp_event_ok),
      .rsp_event_thermal      (rsp_event_thermal),
      .rsp_event_forced       (rsp_event_forced),
      .rsp_event_heartbeat    (rsp_event_heartbeat),
      .rsp_bin_count          (rsp_bin_count),
      .csr_we                 (csr_we),
      .csr_index              (csr_index),
      .csr_wdata              (csr_wdata),
      .mismatch_count         (mismatch_count),
      .responses_owed         (responses_owed)
   );

   // ---------------------------------------------------------------------------------
   // Item builders. Every field is randomized first so that the fields a command
   // ignores still toggle; the builder then sets the fields that matter.
   // ---------------------------------------------------------------------------------
   function automatic request_type random_request();
      request_type r;
      r.command            = cmd_type'($urandom_range(0, 3));
      r.trigger_code       = TRIG_W'($urandom);
      r.board_checksum     = CSUM_W'($urandom);
      r.checksum_low_half  = HALF_W'($urandom);
      r.checksum_high_half = HALF_W'($urandom);
      r.event_seconds      = SEC_W'($urandom);
      r.channel            = CHAN_W'($urandom);
      r.sample_value       = SAMPLE_W'($urandom);
      r.histogram_kind     = KIND_W'($urandom);
      r.bin_index          = BIN_W'($urandom);
      return r;
   endfunction

   // good: checksum words agree with the board checksum; otherwise they never do
   function automatic request_type header_item(input logic [TRIG_W-1:0] trig,
                                               input logic [SEC_W-1:0] sec, input bit good);
      request_type r;
      r = random_request();
      r.command        = CMD_HEADER;
      r.trigger_code   = trig;
      r.event_seconds  = sec;
      r.board_checksum = good ? {r.checksum_high_half, r.checksum_low_half}
                              : ~{r.checksum_high_half, r.checksum_low_half};
      return r;
   endfunction

   function automatic request_type sample_item(input logic [CHAN_W-1:0] ch,
                                               input logic [SAMPLE_W-1:0] value);
      request_type r;
      r = random_request();
      r.command      = CMD_SAMPLE;
      r.channel      = ch;
      r.sample_value = value;
      return r;
   endfunction

   function automatic request_type read_item(input logic [CHAN_W-1:0] ch,
                                             input logic [KIND_W-1:0] kind,
                                             input logic [BIN_W-1:0] bin);
      request_type r;
      r = random_request();
      r.command        = CMD_READ;
      r.channel        = ch;
      r.histogram_kind = kind;
      r.bin_index      = bin;
      return r;
   endfunction

   // ---------------------------------------------------------------------------------
   // Request side. A transfer completes at the first edge with req_ready high; valid
   // and payload stay put until then. Valid is lowered only by the idle paths.
   // ---------------------------------------------------------------------------------
   task automatic send(input request_type item);
      req_valid              <= 1'b1;
      req_command            <= item.command;
      req_trigger_code       <= item.trigger_code;
      req_board_checksum     <= item.board_checksum;
      req_checksum_low_half  <= item.checksum_low_half;
      req_checksum_high_half <= item.checksum_high_half;
      req_event_seconds      <= item.event_seconds;
      req_channel            <= item.channel;
      req_sample_value       <= item.sample_value;
      req_histogram_kind     <= item.histogram_kind;
      req_bin_index          <= item.bin_index;
      do @(posedge clock); while (!req_ready);
      if (item.command != CMD_UNUSED)
         items_sent++;
   endtask

   task automatic idle_sender(input int unsigned cycles);
      req_valid <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   // Called after each transfer: ends a burst with a gap, then picks the next burst.
   // Long bursts give stretches with no sender idling at all.
   task automatic pace();
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         idle_sender($urandom_range(1, 8));
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                  : $urandom_range(0, 8);
      end
   endtask

   // Sender pause until every transfer so far has its response back.
   task automatic wait_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (responses_owed != 0);
   endtask

   task automatic configure(input logic check, input logic beat);
      wait_drained();
      csr_we    <= 1'b1;
      csr_index <= CSR_CHECKSUM_CHECK_ENABLE;
      csr_wdata <= check;
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= CSR_HEARTBEAT_ENABLE;
      csr_wdata <= beat;
      @(posedge clock);
      csr_we    <= 1'b0;
   endtask

   // Sample values bunch in the low bins so that reads find counts.
   function automatic logic [SAMPLE_W-1:0] pick_sample();
      case ($urandom_range(0, 9))
         0:       return SAMPLE_W'($urandom_range(4092, 4095));
         1, 2:    return SAMPLE_W'($urandom);
         default: return SAMPLE_W'($urandom_range(0, 31));
      endcase
   endfunction

   function automatic logic [BIN_W-1:0] pick_bin();
      case ($urandom_range(0, 9))
         0:       return '1;
         1, 2:    return BIN_W'($urandom);
         default: return BIN_W'($urandom_range(0, 7));
      endcase
   endfunction

   // One well-formed event: a header, a few samples and maybe some reads.
   task automatic send_random_event();
      logic [TRIG_W-1:0] trig;
      logic [SEC_W-1:0]  sec;
      int unsigned       pick;
      pick = $urandom_range(0, 99);
      if (pick < 45)
         trig = TRIG_THERMAL;
      else if (pick < 80)
         trig = TRIG_FORCED;
      else
         trig = TRIG_W'($urandom);
      sec = SEC_W'($urandom);
      if (trig == TRIG_THERMAL) begin
         // mostly continue the one-second chain so heartbeats keep coming
         case ($urandom_range(0, 9))
            0, 1: sec = SEC_W'($urandom);       // jump: not a heartbeat
            2:    sec = last_beat_sec;          // same second again
            3:    sec = last_beat_sec + 2;      // a second missed
            default: begin
               sec = last_beat_sec + 1;
               last_beat_sec = sec;
            end
         endcase
      end
      send(header_item(trig, sec, $urandom_range(0, 9) < 8));
      pace();
      repeat ($urandom_range(0, 6)) begin
         send(sample_item(CHAN_W'($urandom), pick_sample()));
         pace();
      end
      repeat ($urandom_range(0, 2)) begin
         send(read_item(CHAN_W'($urandom), KIND_W'($urandom), pick_bin()));
         pace();
      end
   endtask

   // Mostly events, the rest single items of any command with random content.
   task automatic run_phase(input int unsigned count);
      int unsigned goal;
      goal = items_sent + count;
      while (items_sent < goal) begin
         if ($urandom_range(0, 99) < 85) begin
            send_random_event();
         end else begin
            send(random_request());
            pace();
         end
      end
   endtask

   // ---------------------------------------------------------------------------------
   // Response side: stall patterns, each kept for a random length, plus one long
   // hold on request. The hold is counted here so the sender keeps offering items.
   // ---------------------------------------------------------------------------------
   initial begin : receiver
      rx_mode_type mode;
      int unsigned left;
      mode = RX_STEADY;
      left = 0;
      forever begin
         @(posedge clock);
         if (hold_request) begin
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_request = 1'b0;
         end
         if (left == 0) begin
            mode = rx_mode_type'($urandom_range(0, 3));
            left = $urandom_range(10, 80);
         end
         left--;
         case (mode)
            RX_STEADY: rsp_ready <= 1'b1;
            RX_MOSTLY: rsp_ready <= ($urandom_range(0, 3) != 0);
            RX_SPARSE: rsp_ready <= ($urandom_range(0, 3) == 0);
            default:   rsp_ready <= ~rsp_ready;
         endcase
      end
   end

   // Ends the run if neither channel moves a transfer for too long.
   initial begin : watchdog
      int unsigned quiet;
      quiet = 0;
      while (quiet < QUIET_LIMIT) begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
            quiet = 0;
         else
            quiet++;
      end
      $display("Verification failed");
      $finish;
   end

   // ---------------------------------------------------------------------------------
   // Main sequence
   // ---------------------------------------------------------------------------------
   initial begin : stimulus
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Registers are taken during the clearing pass; nothing is in flight yet.
      configure(1'b1, 1'b1);

      // --- directed part ---
      // before any header: the sample is dropped and the read sees an empty store
      send(sample_item(2'd1, 12'd2048));
      send(read_item(2'd1, KIND_W'(KIND_ALL), 10'd512));
      begin
         request_type r;
         r = random_request();
         r.command = CMD_UNUSED;
         send(r);
      end
      // first header near the top of the time range seeds the thermal reference
      send(header_item(TRIG_THERMAL, 32'hFFFF_FFFE, 1'b1));
      // one second later: heartbeat; checksum words all zero
      begin
         request_type r;
         r = header_item(TRIG_THERMAL, 32'hFFFF_FFFF, 1'b1);
         r.board_checksum     = '0;
         r.checksum_low_half  = '0;
         r.checksum_high_half = '0;
         send(r);
      end
      send(sample_item(2'd0, 12'd0));
      send(sample_item(2'd3, 12'd4095));
      // wraps to time zero: a heartbeat that leaves no heartbeat on record;
      // checksum words all ones
      begin
         request_type r;
         r = header_item(TRIG_THERMAL, 32'd0, 1'b1);
         r.board_checksum     = '1;
         r.checksum_low_half  = '1;
         r.checksum_high_half = '1;
         send(r);
      end
      send(sample_item(2'd3, 12'd4095));
      // back to testing against the last thermal time
      send(header_item(TRIG_THERMAL, 32'd1, 1'b1));
      send(header_item(TRIG_THERMAL, 32'd2, 1'b1));
      send(sample_item(2'd2, 12'd3));
      // forced with a bad checksum: flags report the class, sample dropped
      send(header_item(TRIG_FORCED, SEC_W'($urandom), 1'b0));
      send(sample_item(2'd2, 12'd3));
      send(header_item(TRIG_FORCED, SEC_W'($urandom), 1'b1));
      send(sample_item(2'd2, 12'd3));
      // other trigger word: counts only in the all-triggers histogram
      send(header_item(16'hFFFF, SEC_W'($urandom), 1'b1));
      send(sample_item(2'd2, 12'd3));
      // thermal but a gap of several seconds: no heartbeat
      send(header_item(TRIG_THERMAL, 32'd7, 1'b1));
      send(sample_item(2'd0, 12'd0));
      for (int k = 0; k < KINDS; k++)
         send(read_item(2'd3, KIND_W'(k), 10'd1023));
      send(read_item(2'd0, KIND_W'(KIND_THM), 10'd0));
      send(read_item(2'd2, KIND_W'(KIND_FRC), 10'd0));
      last_beat_sec = 32'd2;

      // --- random part, several register settings ---
      configure(1'b1, 1'b1);
      run_phase(80);
      // Long receiver hold while items keep coming back to back: the block fills
      // and stalls its input. Then the sender waits for every response.
      hold_request = 1'b1;
      repeat (16)
         send(sample_item(CHAN_W'($urandom), pick_sample()));
      wait_drained();
      run_phase(70);

      configure(1'b0, 1'b0);
      run_phase(120);
      configure(1'b1, 1'b0);
      run_phase(120);
      configure(1'b0, 1'b1);
      run_phase(110);

      wait_drained();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && responses_owed == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule
